// ===== rtl/fire_blur_line_filter_defines.svh =====
// assertion macros shared by the fire blur line filter modules
`ifndef FIRE_BLUR_LINE_FILTER_DEFINES_SVH
`define FIRE_BLUR_LINE_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// cond holds at an edge, prop must hold at the same edge
`define FBL_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("fire blur line filter: implication check failed");

// cond holds at an edge, prop must hold at the next edge
`define FBL_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("fire blur line filter: next-cycle check failed");

`else

`define FBL_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define FBL_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== rtl/fbl_pkg.sv =====
// shared constants and types of the fire blur line filter
package fbl_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MIN_WIDTH  = 4;
    localparam int MIN_HEIGHT = 2;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W     = PIX_W + 2;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // result queue
    localparam int BURST_MAX   = 3;
    localparam int PUSH_N_W    = $clog2(BURST_MAX + 1);
    localparam int QUEUE_DEPTH = 16;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             eof;
    } result_t;

    // words produced by one item, in output order from index 0
    typedef struct packed {
        logic [PUSH_N_W-1:0]        count;
        result_t [BURST_MAX-1:0]    word;
    } push_t;

endpackage

// ===== rtl/fbl_line_ram.sv =====
// single-port line memory, read-first, with a registered read port
module fbl_line_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg     <= mem_reg[addr];
            mem_reg[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fbl_filter_core.sv =====
// position counters, line store access and the four-tap blur datapath
`include "fire_blur_line_filter_defines.svh"

module fbl_filter_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbl_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fbl_pkg::PIX_W-1:0]      pixel_in,
    input  logic [fbl_pkg::Q_CNT_W-1:0]    queue_count,
    output fbl_pkg::push_t                 push
);
    import fbl_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             first;
        logic             emit_a;
        logic             row_end;
        logic             live;
        logic             active;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } stage_t;

    localparam int ROOM_IDLE = QUEUE_DEPTH - BURST_MAX;
    localparam int ROOM_BUSY = QUEUE_DEPTH - 2 * BURST_MAX;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [COL_W-1:0] column_count_reg, column_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic             frame_seen_reg, frame_seen_next;
    logic             s1_valid_reg;
    stage_t           s1_reg, s1_next;
    logic [23:0]      cur_window_reg, cur_window_next;
    logic [15:0]      prev_window_reg, prev_window_next;

    logic [COL_W-1:0] w_last, c;
    logic [ROW_W-1:0] h_last, r;
    logic             accept;
    logic [PIX_W-1:0] above;
    logic [23:0]      cur;
    logic [15:0]      pb;
    logic [SUM_W-1:0] sum_a, sum_b, sum_c;
    logic             have_a, have_bc;
    result_t          res_a, res_b, res_c;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_W'(WIDTH_RESET);
            frame_height_reg <= CFG_W'(HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    // saturated last column and last row
    always_comb
    begin
        priority if (frame_width_reg < CFG_W'(MIN_WIDTH))
            w_last = COL_W'(MIN_WIDTH - 1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_last = COL_W'(MAX_WIDTH - 1);
        else
            w_last = COL_W'(frame_width_reg - CFG_W'(1));

        priority if (frame_height_reg < CFG_W'(MIN_HEIGHT))
            h_last = ROW_W'(MIN_HEIGHT - 1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_last = ROW_W'(MAX_HEIGHT - 1);
        else
            h_last = ROW_W'(frame_height_reg - CFG_W'(1));
    end

    // keep room for the item in flight plus the one entering
    assign in_stall = s1_valid_reg ? (queue_count > Q_CNT_W'(ROOM_BUSY))
                                   : (queue_count > Q_CNT_W'(ROOM_IDLE));
    assign accept   = in_valid && !in_stall;

    assign c = (column_count_reg < w_last) ? column_count_reg : w_last;
    assign r = (row_count_reg < h_last) ? row_count_reg : h_last;

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        frame_seen_next   = frame_seen_reg;
        if (accept)
        begin
            if (c == w_last)
            begin
                column_count_next = '0;
                if (r == h_last)
                begin
                    row_count_next  = '0;
                    frame_seen_next = 1'b1;
                end
                else
                    row_count_next = r + ROW_W'(1);
            end
            else
            begin
                column_count_next = c + COL_W'(1);
                row_count_next    = r;
            end
        end

        s1_next.pixel   = pixel_in;
        s1_next.first   = (c == '0);
        s1_next.emit_a  = (c >= COL_W'(2));
        s1_next.row_end = (c == w_last);
        s1_next.live    = (r != '0);
        s1_next.active  = (r != '0) || frame_seen_reg;
        s1_next.column  = c;
        s1_next.row     = (r != '0) ? (r - ROW_W'(1)) : h_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            frame_seen_reg   <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            frame_seen_reg   <= frame_seen_next;
            s1_valid_reg     <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
    end

    // row above: read the old pixel and store the new one at the same column
    fbl_line_ram #(
        .ADDR_W (COL_W),
        .DATA_W (PIX_W)
    ) u_line_ram (
        .clk   (clk),
        .en    (accept),
        .addr  (c),
        .wdata (pixel_in),
        .rdata (above)
    );

    // windows restart at column zero so left neighbours read as zero
    assign cur = s1_reg.first ? '0 : cur_window_reg;
    assign pb  = s1_reg.first ? '0 : prev_window_reg;

    assign cur_window_next  = {cur[15:0], s1_reg.pixel};
    assign prev_window_next = {pb[7:0], above};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_window_reg  <= '0;
            prev_window_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            cur_window_reg  <= cur_window_next;
            prev_window_reg <= prev_window_next;
        end
    end

    assign sum_a = SUM_W'(pb[15:8]) + SUM_W'(pb[7:0]) + SUM_W'(cur[23:16])
                 + SUM_W'(s1_reg.pixel);
    assign sum_b = SUM_W'(pb[7:0]) + SUM_W'(above) + SUM_W'(cur[15:8]);
    assign sum_c = SUM_W'(above) + SUM_W'(cur[7:0]);

    assign have_a  = s1_valid_reg && s1_reg.emit_a && s1_reg.active;
    assign have_bc = s1_valid_reg && s1_reg.row_end && s1_reg.active;

    always_comb
    begin
        res_a.pixel  = s1_reg.live ? sum_a[SUM_W-1:2] : '0;
        res_a.column = s1_reg.column - COL_W'(2);
        res_a.row    = s1_reg.row;
        res_a.last   = !have_bc;
        res_a.eof    = 1'b0;

        res_b.pixel  = s1_reg.live ? sum_b[SUM_W-1:2] : '0;
        res_b.column = s1_reg.column - COL_W'(1);
        res_b.row    = s1_reg.row;
        res_b.last   = 1'b0;
        res_b.eof    = 1'b0;

        // bottom row of the output frame ends on the row-end word
        res_c.pixel  = s1_reg.live ? sum_c[SUM_W-1:2] : '0;
        res_c.column = s1_reg.column;
        res_c.row    = s1_reg.row;
        res_c.last   = 1'b1;
        res_c.eof    = !s1_reg.live;

        push.count   = PUSH_N_W'(have_a) + (have_bc ? PUSH_N_W'(2) : '0);
        push.word[0] = have_a ? res_a : res_b;
        push.word[1] = have_a ? res_b : res_c;
        push.word[2] = res_c;
    end

    `FBL_ASSERT_NEXT(a_accept_reaches_stage, clk, rst_n, accept, s1_valid_reg)
    `FBL_ASSERT_IMPLY(a_push_needs_item, clk, rst_n, push.count != '0, s1_valid_reg)
    `FBL_ASSERT_IMPLY(a_accept_has_room, clk, rst_n, accept, int'(queue_count) <= ROOM_IDLE)

endmodule

// ===== rtl/fbl_result_queue.sv =====
// result queue taking up to three words a cycle and delivering one while out_stall is low
`include "fire_blur_line_filter_defines.svh"

module fbl_result_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fbl_pkg::push_t              push,
    output logic [fbl_pkg::Q_CNT_W-1:0] count,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [fbl_pkg::PIX_W-1:0]   pixel_out,
    output logic [fbl_pkg::COL_W-1:0]   out_column,
    output logic [fbl_pkg::ROW_W-1:0]   out_row,
    output logic                        last_of_burst,
    output logic                        end_of_frame
);
    import fbl_pkg::*;

    result_t             slot_reg [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;
    logic                pop;
    result_t             head;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign count     = count_reg;

    assign wr_ptr_next = wr_ptr_reg + Q_IDX_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + Q_IDX_W'(pop);
    assign count_next  = count_reg + Q_CNT_W'(push.count) - Q_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < BURST_MAX; k++)
        begin
            if (k < int'(push.count))
                slot_reg[wr_ptr_reg + Q_IDX_W'(k)] <= push.word[k];
        end
    end

    assign head          = slot_reg[rd_ptr_reg];
    assign pixel_out     = head.pixel;
    assign out_column    = head.column;
    assign out_row       = head.row;
    assign last_of_burst = head.last;
    assign end_of_frame  = head.eof;

    `FBL_ASSERT_IMPLY(a_no_overflow, clk, rst_n, 1'b1, count_next <= Q_CNT_W'(QUEUE_DEPTH))
    `FBL_ASSERT_NEXT(a_pop_lowers, clk, rst_n, pop && ~|push.count, count_reg < $past(count_reg))

endmodule

// ===== rtl/fire_blur_line_filter.sv =====
// Fire blur line filter: takes one 8-bit pixel per clock in raster order while the
// input is not stalled; the single-port line store is read and written at the same
// column for each pixel taken. Output pixel (x,y) is the four-tap sum of p(x,y),
// p(x+1,y), p(x-1,y+1), p(x+2,y+1) shifted right by two, with neighbours outside
// the row taken as zero; the bottom row is zero and leaves while row 0 of the next
// frame arrives. A pixel's words pass the stage register into the result queue,
// so results lag one row plus two pixels of input. Each pixel gives zero to three
// words; a 16-word queue absorbs the three-word bursts at row ends, and the input
// stalls while the queue could not hold the words of the pixel in flight together
// with those of the next one. The line store needs no clearing after reset.
// frame_width (index 0, reset 640) and frame_height (index 1, reset 480) are
// saturated to 4..2048 and 2..2048 and must be written only while the block is
// idle; the block itself does not enforce this.
module fire_blur_line_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbl_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fbl_pkg::PIX_W-1:0]      pixel_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fbl_pkg::PIX_W-1:0]      pixel_out,
    output logic [fbl_pkg::COL_W-1:0]      out_column,
    output logic [fbl_pkg::ROW_W-1:0]      out_row,
    output logic                           last_of_burst,
    output logic                           end_of_frame
);
    import fbl_pkg::*;

    push_t              push;
    logic [Q_CNT_W-1:0] queue_count;

    fbl_filter_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_in    (pixel_in),
        .queue_count (queue_count),
        .push        (push)
    );

    fbl_result_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .count         (queue_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_out     (pixel_out),
        .out_column    (out_column),
        .out_row       (out_row),
        .last_of_burst (last_of_burst),
        .end_of_frame  (end_of_frame)
    );

endmodule

// ===== bench/tb_fire_blur_line_filter.sv =====
`timescale 1ns / 100ps
// testbench for the fire blur line filter: streams frames and checks every blurred word
module tb_fire_blur_line_filter;
    import fbl_pkg::*;

    localparam int CYCLE_LIMIT   = 900000;
    localparam int RANDOM_PIXELS = 100;
    localparam int IDLE_PERCENT  = 26;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [PIX_W-1:0]     pixel_in = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PIX_W-1:0]     pixel_out;
    logic [COL_W-1:0]     out_column;
    logic [ROW_W-1:0]     out_row;
    logic                 last_of_burst;
    logic                 end_of_frame;

    // mirror of the filter state
    logic [CFG_W-1:0] width_reg = CFG_W'(WIDTH_RESET);
    logic [CFG_W-1:0] height_reg = CFG_W'(HEIGHT_RESET);
    bit [PIX_W-1:0]   line_mem [MAX_WIDTH];
    bit [31:0]        row_win = '0;
    bit [15:0]        above_win = '0;
    int unsigned      col_cnt = 0;
    int unsigned      row_cnt = 0;
    bit               seen_frame = 1'b0;
    result_t          due_words [$];

    int unsigned cycles = 0;
    int unsigned error_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned words_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned calm_from = 0;
    int unsigned calm_to = 0;
    bit          calm = 1'b0;

    fire_blur_line_filter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_in      (pixel_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_out     (pixel_out),
        .out_column    (out_column),
        .out_row       (out_row),
        .last_of_burst (last_of_burst),
        .end_of_frame  (end_of_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycles, due_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    task automatic flag_error(input string msg);
        if (error_count < 40)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lo,
                                               input int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic result_t make_word(input int unsigned val, input int unsigned col,
                                          input int unsigned row, input bit eof);
        result_t word;
        word.pixel  = PIX_W'(val);
        word.column = COL_W'(col);
        word.row    = ROW_W'(row);
        word.last   = 1'b0;
        word.eof    = eof;
        return word;
    endfunction

    // blurred words caused by one accepted pixel
    task automatic blur_step(input logic [PIX_W-1:0] p);
        int unsigned w, h, c, r, sum;
        bit [PIX_W-1:0] up;
        bit [15:0] left_above;
        result_t burst [$];
        w = clamp_size(width_reg, MIN_WIDTH, MAX_WIDTH);
        h = clamp_size(height_reg, MIN_HEIGHT, MAX_HEIGHT);
        c = (col_cnt < w - 1) ? col_cnt : w - 1;
        r = (row_cnt < h - 1) ? row_cnt : h - 1;
        if (c == 0)
        begin
            row_win = '0;
            above_win = '0;
        end
        up = line_mem[c];
        line_mem[c] = p;
        left_above = above_win;
        row_win = {row_win[23:0], p};
        above_win = {above_win[7:0], up};

        if (r >= 1)
        begin
            if (c >= 2)
            begin
                sum = left_above[15:8] + left_above[7:0] + row_win[31:24] + p;
                burst.push_back(make_word(sum >> 2, c - 2, r - 1, 1'b0));
            end
            // right edge: the taps beyond the row read zero
            if (c == w - 1)
            begin
                sum = above_win[15:8] + above_win[7:0] + row_win[23:16];
                burst.push_back(make_word(sum >> 2, c - 1, r - 1, 1'b0));
                sum = above_win[7:0] + row_win[15:8];
                burst.push_back(make_word(sum >> 2, c, r - 1, 1'b0));
            end
        end
        else if (seen_frame)
        begin
            // bottom row of the earlier frame drains as zeros
            if (c >= 2)
                burst.push_back(make_word(0, c - 2, h - 1, 1'b0));
            if (c == w - 1)
            begin
                burst.push_back(make_word(0, c - 1, h - 1, 1'b0));
                burst.push_back(make_word(0, c, h - 1, 1'b1));
            end
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            due_words.push_back(burst[i]);

        if (c == w - 1)
        begin
            col_cnt = 0;
            if (r == h - 1)
            begin
                row_cnt = 0;
                seen_frame = 1'b1;
            end
            else
                row_cnt = r + 1;
        end
        else
        begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endtask

    always @(posedge clk)
    begin : check_words
        result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (due_words.size() == 0)
                flag_error($sformatf("word with nothing due: pix %0d col %0d row %0d",
                                     pixel_out, out_column, out_row));
            else
            begin
                want = due_words.pop_front();
                words_checked++;
                if (pixel_out !== want.pixel || out_column !== want.column ||
                    out_row !== want.row || last_of_burst !== want.last ||
                    end_of_frame !== want.eof)
                    flag_error($sformatf({"got pix %0d col %0d row %0d last %b eof %b, ",
                                          "want pix %0d col %0d row %0d last %b eof %b"},
                                         pixel_out, out_column, out_row, last_of_burst,
                                         end_of_frame, want.pixel, want.column, want.row,
                                         want.last, want.eof));
            end
        end
    end

    function automatic logic [PIX_W-1:0] any_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] p);
        calm = (pixels_sent >= calm_from) && (pixels_sent < calm_to);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= p;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        blur_step(p);
        pixels_sent++;
    endtask

    task automatic send_to_frame_end();
        while (!(col_cnt == 0 && row_cnt == 0))
            send_pixel(any_pixel());
    endtask

    task automatic send_frame();
        send_pixel(any_pixel());
        send_to_frame_end();
    endtask

    // hold the input until every due word has left, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one write cycle, then a quiet wait so writes never meet in one time step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_reg = CFG_W'(val);
        else
            height_reg = CFG_W'(val);
        reg_writes++;
        @(posedge clk);
    endtask

    // reset geometry, first frame silent in row 0, then shrunk early in that row
    task automatic test_reset_geometry();
        repeat (30) send_pixel(any_pixel());
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 36);
        write_reg(REG_FRAME_HEIGHT, 2);
        send_to_frame_end();
    endtask

    // all-ones width saturates high, the row is cut short before it ends
    task automatic test_widest_row();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 4095);
        repeat (40) send_pixel(any_pixel());
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 48);
        send_to_frame_end();
    endtask

    // smallest frame through saturation of zero sizes, pixel extremes
    task automatic test_smallest_frame();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        repeat (8) send_pixel(8'hFF);
        repeat (8) send_pixel(8'h00);
        for (int i = 0; i < 8; i++)
            send_pixel(((i + i / 4) % 2) ? 8'h00 : 8'hFF);
    endtask

    // bottom row still pending while the height changes
    task automatic test_height_between_frames();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 6);
        write_reg(REG_FRAME_HEIGHT, 3);
        send_frame();
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 5);
        send_frame();
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 2);
        send_frame();
    endtask

    // counters beyond a shrunk size fold onto the last column and row
    task automatic test_shrink_mid_frame();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 16);
        write_reg(REG_FRAME_HEIGHT, 6);
        repeat (2 * 16 + 9) send_pixel(any_pixel());
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 5);
        repeat (5 + 1) send_pixel(any_pixel());
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 3);
        send_to_frame_end();
    endtask

    // all-ones height saturates high, then the bottom row drains before the height drops
    task automatic test_tallest_frame();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 4095);
        repeat (4 * 7) send_pixel(any_pixel());
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 8);
        send_to_frame_end();
        repeat (4) send_pixel(any_pixel());
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 2);
        send_to_frame_end();
    endtask

    task automatic test_random_frames();
        int unsigned start, w, h, cut;
        start = pixels_sent;
        calm_from = start + 10;
        calm_to = start + 90;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            wait_idle();
            w = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(4, 12);
            h = $urandom_range(2, 6);
            if ($urandom_range(7) == 0)
            begin
                w = MIN_WIDTH;
                write_reg(REG_FRAME_WIDTH, $urandom_range(0, MIN_WIDTH));
            end
            else
                write_reg(REG_FRAME_WIDTH, w);
            if ($urandom_range(7) == 0)
            begin
                h = MIN_HEIGHT;
                write_reg(REG_FRAME_HEIGHT, $urandom_range(0, MIN_HEIGHT));
            end
            else
                write_reg(REG_FRAME_HEIGHT, h);
            // broken frame: sizes shrink partway through
            if ($urandom_range(3) == 0)
            begin
                cut = $urandom_range(1, w * h - 1);
                repeat (cut) send_pixel(any_pixel());
                wait_idle();
                if ($urandom_range(1))
                    write_reg(REG_FRAME_WIDTH, $urandom_range(MIN_WIDTH, w));
                else
                    write_reg(REG_FRAME_HEIGHT, $urandom_range(MIN_HEIGHT, h));
                send_to_frame_end();
            end
            repeat ($urandom_range(1, 2)) send_frame();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_geometry();
        test_widest_row();
        test_smallest_frame();
        test_height_between_frames();
        test_shrink_mid_frame();
        test_tallest_frame();
        test_random_frames();

        wait_idle();
        repeat (8) @(posedge clk);

        $display("covered %0d pixels and %0d checked words over %0d register writes",
                 pixels_sent, words_checked, reg_writes);
        $display("saturated sizes, mid-frame shrinks and height changes between frames");
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
